FILE: rtl/core/bar_falloff_smoother_core_macros.svh
// Assertion macros shared by the bar falloff smoother checkers.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef BAR_FALLOFF_SMOOTHER_CORE_MACROS_SVH
`define BAR_FALLOFF_SMOOTHER_CORE_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define BFS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define BFS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/bfs_pkg.sv
// Package for the bar falloff smoother: widths, register codes, shared types.
// Used by the state store, datapath and top level; depends on nothing.
`timescale 1ns / 1ps

package bfs_pkg;

  localparam int unsigned MAX_BARS    = 256;
  localparam int unsigned BAR_W       = 8;
  localparam int unsigned ADDR_W      = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
  localparam int unsigned LEVEL_W     = 24;
  localparam int unsigned OUT_W       = 31;
  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned LIMIT_W     = 24;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned GRAV_SHIFT  = 8;
  localparam int unsigned INTEG_SHIFT = 16;
  localparam int unsigned SQ_W        = 2 * CNT_W;
  localparam int unsigned DROPF_W     = GAIN_W + SQ_W;
  localparam int unsigned DROP_W      = DROPF_W - GRAV_SHIFT;
  localparam int unsigned PROD_W      = DATA_W + GAIN_W + 1;
  localparam int unsigned SAT_W       = DROP_W + 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 24;

  localparam logic [CNT_W-1:0]   FALL_MAX     = '1;
  localparam logic [GAIN_W-1:0]  GRAVITY_RST  = 16'd51;
  localparam logic [GAIN_W-1:0]  INTEGRAL_RST = 16'd45875;
  localparam logic [LIMIT_W-1:0] LIMIT_RST    = 24'd1600;
  localparam logic               AUTOSENS_RST = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRAVITY  = 2'd0,
    REG_INTEGRAL = 2'd1,
    REG_LIMIT    = 2'd2,
    REG_AUTOSENS = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    KIND_LEVEL = 1'b0,
    KIND_CLEAR = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic [GAIN_W-1:0]  gravity;
    logic [GAIN_W-1:0]  integral;
    logic [LIMIT_W-1:0] limit;
    logic               autosens;
  } cfg_t;

  // per-bar state word; held_peak only ever holds a raw level
  typedef struct packed {
    logic [DATA_W-1:0]  last_out;
    logic [LEVEL_W-1:0] held_peak;
    logic [CNT_W-1:0]   fall_count;
    logic [DATA_W-1:0]  integ;
  } state_t;

  localparam int unsigned STATE_W = $bits(state_t);

  typedef struct packed {
    item_kind_e         kind;
    logic [BAR_W-1:0]   bar;
    logic [LEVEL_W-1:0] level;
  } tag_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    state_t            data;
  } wr_t;

  typedef struct packed {
    logic             vld;
    logic [BAR_W-1:0] bar;
    logic [OUT_W-1:0] level;
    logic             over;
  } res_t;

  function automatic logic [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(signed'(33'sh0_7FFF_FFFF));
    lo = SAT_W'(signed'(33'sh1_8000_0000));
    if (v > hi) begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

FILE: rtl/core/bfs_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// Read-first on an address collision. No dependencies.
`timescale 1ns / 1ps

module bfs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/bfs_state_store.sv
// Per-bar state store: state RAM plus one written flag per bar.
// A bar never written since reset reads as all zero. Depends on bfs_pkg, bfs_ram.
`timescale 1ns / 1ps

module bfs_state_store (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      re_i,
  input  logic [bfs_pkg::ADDR_W-1:0] raddr_i,
  input  bfs_pkg::wr_t              wr_i,
  output bfs_pkg::state_t           rd_state_o
);

  logic [bfs_pkg::MAX_BARS-1:0] vld_q;
  logic                         rvld_q;
  logic [bfs_pkg::STATE_W-1:0]  rdata;

  bfs_ram #(
    .WIDTH (bfs_pkg::STATE_W),
    .DEPTH (bfs_pkg::MAX_BARS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_i.we),
    .waddr_i (wr_i.addr),
    .wdata_i (wr_i.data),
    .re_i    (re_i),
    .raddr_i (raddr_i),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_i.we) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rd_state_o = rvld_q ? bfs_pkg::state_t'(rdata) : '0;

endmodule

FILE: rtl/core/bfs_datapath.sv
// Four-stage falloff and integrator pipeline between state read and write-back.
// Also flags bars still in flight. Depends on bfs_pkg.
`timescale 1ns / 1ps

module bfs_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       in_vld_i,
  input  bfs_pkg::tag_t              in_tag_i,
  input  logic [bfs_pkg::BAR_W-1:0]  cand_bar_i,
  output logic                       hazard_o,
  input  bfs_pkg::state_t            rd_state_i,
  input  bfs_pkg::cfg_t              cfg_i,
  output bfs_pkg::wr_t               wr_o,
  output bfs_pkg::res_t              res_o
);

  localparam int unsigned DW = bfs_pkg::DATA_W;
  localparam int unsigned LW = bfs_pkg::LEVEL_W;
  localparam int unsigned SW = bfs_pkg::SAT_W;
  localparam int unsigned PW = bfs_pkg::PROD_W;
  localparam int unsigned DSH_W = PW - bfs_pkg::INTEG_SHIFT;

  logic                          s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  bfs_pkg::tag_t                 s1_tag_q, s2_tag_q, s3_tag_q, s4_tag_q;
  bfs_pkg::state_t               s2_st_q, s3_st_q, s4_st_q;
  logic [bfs_pkg::SQ_W-1:0]      s2_sq_q, s2_sq_d;
  logic                          s2_fall_q, s2_fall_d, s3_fall_q;
  logic [bfs_pkg::DROPF_W-1:0]   s3_dropf_q, s3_dropf_d;
  logic [PW-1:0]                 s3_prod_q, s3_prod_d;
  logic [DW-1:0]                 s4_f_q, s4_f_d, s4_d_q, s4_d_d;
  bfs_pkg::state_t               s4_st_d;

  logic                          grav_on, integ_on, falling, neg;
  logic [bfs_pkg::DROP_W-1:0]    drop;
  logic [DW-1:0]                 fv, lvl_ext, sres, fo;
  logic [PW-1:0]                 mag;
  logic [DSH_W-1:0]              dsh;
  logic [DW:0]                   sum;
  bfs_pkg::state_t               nst;

  assign grav_on  = cfg_i.gravity != '0;
  assign integ_on = cfg_i.integral != '0;

  // stage 1: count squared, falling test against last output
  assign s2_sq_d   = bfs_pkg::SQ_W'(rd_state_i.fall_count) *
                     bfs_pkg::SQ_W'(rd_state_i.fall_count);
  assign s2_fall_d = $signed({{(DW+1-LW){1'b0}}, s1_tag_q.level}) <
                     $signed({rd_state_i.last_out[DW-1], rd_state_i.last_out});

  // stage 2: gravity drop and integrator decay products
  assign s3_dropf_d = bfs_pkg::DROPF_W'(cfg_i.gravity) * bfs_pkg::DROPF_W'(s2_sq_q);
  assign s3_prod_d  = PW'({{(PW-DW){s2_st_q.integ[DW-1]}}, s2_st_q.integ} *
                          {{(PW-bfs_pkg::GAIN_W){1'b0}}, cfg_i.integral});

  // stage 3: falloff value and decayed memory, rounded toward zero
  assign drop    = s3_dropf_q[bfs_pkg::DROPF_W-1:bfs_pkg::GRAV_SHIFT];
  assign fv      = bfs_pkg::sat32({{(SW-LW){1'b0}}, s3_st_q.held_peak} -
                                  {{(SW-bfs_pkg::DROP_W){1'b0}}, drop});
  assign lvl_ext = {{(DW-LW){1'b0}}, s3_tag_q.level};
  assign falling = grav_on && s3_fall_q;
  assign s4_f_d  = falling ? fv : lvl_ext;

  assign neg    = s3_prod_q[PW-1];
  assign mag    = neg ? (~s3_prod_q + PW'(1)) : s3_prod_q;
  assign dsh    = neg ? (~mag[PW-1:bfs_pkg::INTEG_SHIFT] + DSH_W'(1))
                      : mag[PW-1:bfs_pkg::INTEG_SHIFT];
  assign s4_d_d = dsh[DW-1:0];

  always_comb begin
    s4_st_d = s3_st_q;
    if (grav_on) begin
      s4_st_d.last_out = s4_f_d;
      if (s3_fall_q) begin
        if (s3_st_q.fall_count != bfs_pkg::FALL_MAX) begin
          s4_st_d.fall_count = s3_st_q.fall_count + bfs_pkg::CNT_W'(1);
        end
      end else begin
        s4_st_d.held_peak  = s3_tag_q.level;
        s4_st_d.fall_count = '0;
      end
    end
  end

  // stage 4: integrate, write back, form the result
  assign sum  = {s4_d_q[DW-1], s4_d_q} + {s4_f_q[DW-1], s4_f_q};
  assign sres = integ_on ? bfs_pkg::sat32({{(SW-DW-1){sum[DW]}}, sum}) : s4_f_q;
  assign fo   = ($signed(sres) < $signed(DW'(1))) ? DW'(1) : sres;

  always_comb begin
    nst = s4_st_q;
    if (integ_on) begin
      nst.integ = sres;
    end
  end

  assign wr_o.we   = s4_vld_q && adv_i;
  assign wr_o.addr = s4_tag_q.bar[bfs_pkg::ADDR_W-1:0];
  assign wr_o.data = (s4_tag_q.kind == bfs_pkg::KIND_CLEAR) ? '0 : nst;

  assign res_o.vld   = s4_vld_q && (s4_tag_q.kind == bfs_pkg::KIND_LEVEL);
  assign res_o.bar   = s4_tag_q.bar;
  assign res_o.level = fo[bfs_pkg::OUT_W-1:0];
  assign res_o.over  = cfg_i.autosens &&
                       (fo[bfs_pkg::OUT_W-1:0] > bfs_pkg::OUT_W'(cfg_i.limit));

  assign hazard_o = (s1_vld_q && (s1_tag_q.bar == cand_bar_i)) ||
                    (s2_vld_q && (s2_tag_q.bar == cand_bar_i)) ||
                    (s3_vld_q && (s3_tag_q.bar == cand_bar_i)) ||
                    (s4_vld_q && (s4_tag_q.bar == cand_bar_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else if (adv_i) begin
      s1_vld_q <= in_vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_tag_q   <= in_tag_i;
      s2_tag_q   <= s1_tag_q;
      s2_st_q    <= rd_state_i;
      s2_sq_q    <= s2_sq_d;
      s2_fall_q  <= s2_fall_d;
      s3_tag_q   <= s2_tag_q;
      s3_st_q    <= s2_st_q;
      s3_fall_q  <= s2_fall_q;
      s3_dropf_q <= s3_dropf_d;
      s3_prod_q  <= s3_prod_d;
      s4_tag_q   <= s3_tag_q;
      s4_st_q    <= s4_st_d;
      s4_f_q     <= s4_f_d;
      s4_d_q     <= s4_d_d;
    end
  end

endmodule

FILE: rtl/core/bar_falloff_smoother_core.sv
// Top level of the bar falloff smoother: stream ports, config registers, output register.
// Depends on bfs_pkg, bfs_state_store, bfs_datapath.
//
//   channel   dir  handshake                 payload
//   s_axis    in   s_axis_tvalid/tready      tdata: bar_index, raw_level; tuser: kind
//   m_axis    out  m_axis_tvalid/tready      tdata: out_bar, smoothed_level; tuser: over_limit
//   cfg       in   cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One request per cycle while each names a bar not in flight and no output stall holds
// the pipeline; its result passes stages 1 to 4 and then the output register. A request
// for a bar still in the 4-stage read-modify-write loop waits until that bar's write-back.
// Reset clears all per-bar state at once through one flag per bar; no clearing pass.
// A stalled output holds the pipeline only when the last stage holds a result.
`timescale 1ns / 1ps

module bar_falloff_smoother_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [31:0]                      s_axis_tdata,  // bar_index[7:0], raw_level[31:8]
  input  logic                             s_axis_tuser,  // kind[0]
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [39:0]                      m_axis_tdata,  // out_bar[7:0], smoothed_level[38:8]
  output logic                             m_axis_tuser,  // over_limit[0]
  input  logic                             cfg_we_i,
  input  logic [bfs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bfs_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  bfs_pkg::cfg_t   cfg_q;
  bfs_pkg::tag_t   in_tag;
  bfs_pkg::state_t rd_state;
  bfs_pkg::wr_t    wr;
  bfs_pkg::res_t   res, out_q;
  logic            out_vld_q;
  logic            adv, hazard, accept, in_range;

  assign in_tag.kind  = bfs_pkg::item_kind_e'(s_axis_tuser);
  assign in_tag.bar   = s_axis_tdata[bfs_pkg::BAR_W-1:0];
  assign in_tag.level = s_axis_tdata[bfs_pkg::BAR_W +: bfs_pkg::LEVEL_W];

  assign in_range = {1'b0, in_tag.bar} < (bfs_pkg::BAR_W+1)'(bfs_pkg::MAX_BARS);

  assign adv           = !(res.vld && out_vld_q && !m_axis_tready);
  assign s_axis_tready = adv && !hazard;
  assign accept        = s_axis_tvalid && s_axis_tready;

  bfs_state_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .re_i       (adv),
    .raddr_i    (in_tag.bar[bfs_pkg::ADDR_W-1:0]),
    .wr_i       (wr),
    .rd_state_o (rd_state)
  );

  bfs_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_vld_i   (accept && in_range),
    .in_tag_i   (in_tag),
    .cand_bar_i (in_tag.bar),
    .hazard_o   (hazard),
    .rd_state_i (rd_state),
    .cfg_i      (cfg_q),
    .wr_o       (wr),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gravity  <= bfs_pkg::GRAVITY_RST;
      cfg_q.integral <= bfs_pkg::INTEGRAL_RST;
      cfg_q.limit    <= bfs_pkg::LIMIT_RST;
      cfg_q.autosens <= bfs_pkg::AUTOSENS_RST;
    end else if (cfg_we_i) begin
      case (bfs_pkg::cfg_reg_e'(cfg_idx_i))
        bfs_pkg::REG_GRAVITY:  cfg_q.gravity  <= cfg_data_i[bfs_pkg::GAIN_W-1:0];
        bfs_pkg::REG_INTEGRAL: cfg_q.integral <= cfg_data_i[bfs_pkg::GAIN_W-1:0];
        bfs_pkg::REG_LIMIT:    cfg_q.limit    <= cfg_data_i[bfs_pkg::LIMIT_W-1:0];
        bfs_pkg::REG_AUTOSENS: cfg_q.autosens <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && res.vld) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res.vld) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_q.level, out_q.bar};
  assign m_axis_tuser  = out_q.over;

endmodule

FILE: rtl/core/bfs_checker.sv
// Port-level checker for the bar falloff smoother, bound to the top level.
// Depends on bar_falloff_smoother_core_macros.svh.
`timescale 1ns / 1ps
`include "bar_falloff_smoother_core_macros.svh"

module bfs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  `BFS_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result request dropped while stalled")
  `BFS_ASSERT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
  `BFS_ASSERT(a_level_min, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[38:8] != 31'd0, "smoothed level below one")
  `BFS_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !m_axis_tvalid, "result offered during reset")

endmodule

bind bar_falloff_smoother_core bfs_checker u_bfs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
